// ===== src/ansi_csi_control_decoder_assert.svh =====
// Assertion macros used by the terminal control decoder top level.
`ifndef ANSI_CSI_CONTROL_DECODER_ASSERT_SVH
`define ANSI_CSI_CONTROL_DECODER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ACSI_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ACSI_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/acsi_pkg.sv =====
// Types, codes and constants of the terminal control decoder.
package acsi_pkg;

    localparam int MAX_PARAMS  = 3;
    localparam int PARAM_BITS  = 16;
    localparam int MAX_RESULTS = 3;
    localparam int PCNT_W      = $clog2(MAX_PARAMS + 1);
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int ARG_BITS    = 16;
    localparam int CMD_BITS    = 5;
    localparam int DEC_BASE    = 10;

    // Parser modes; the unused code behaves as ground.
    localparam logic [1:0] MODE_GROUND = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_CSI    = 2'd2;

    localparam logic [CMD_BITS-1:0] CMD_PUTCHAR   = 5'd0;
    localparam logic [CMD_BITS-1:0] CMD_BS        = 5'd1;
    localparam logic [CMD_BITS-1:0] CMD_HTAB      = 5'd2;
    localparam logic [CMD_BITS-1:0] CMD_VTAB      = 5'd3;
    localparam logic [CMD_BITS-1:0] CMD_BEEP      = 5'd4;
    localparam logic [CMD_BITS-1:0] CMD_CR        = 5'd5;
    localparam logic [CMD_BITS-1:0] CMD_LF        = 5'd6;
    localparam logic [CMD_BITS-1:0] CMD_SPACE     = 5'd7;
    localparam logic [CMD_BITS-1:0] CMD_DEL       = 5'd8;
    localparam logic [CMD_BITS-1:0] CMD_SETPOS    = 5'd9;
    localparam logic [CMD_BITS-1:0] CMD_UP        = 5'd10;
    localparam logic [CMD_BITS-1:0] CMD_DOWN      = 5'd11;
    localparam logic [CMD_BITS-1:0] CMD_FWD       = 5'd12;
    localparam logic [CMD_BITS-1:0] CMD_BACK      = 5'd13;
    localparam logic [CMD_BITS-1:0] CMD_SAVE      = 5'd14;
    localparam logic [CMD_BITS-1:0] CMD_RESTORE   = 5'd15;
    localparam logic [CMD_BITS-1:0] CMD_ERASELINE = 5'd16;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR     = 5'd17;
    localparam logic [CMD_BITS-1:0] CMD_REFRESH   = 5'd18;

    localparam logic [7:0] CHAR_BEL       = 8'h07;
    localparam logic [7:0] CHAR_BS        = 8'h08;
    localparam logic [7:0] CHAR_HT        = 8'h09;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_VT        = 8'h0B;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_ESC       = 8'h1B;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_DEL       = 8'h7F;
    localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
    localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_B   = 8'h42;
    localparam logic [7:0] CHAR_UPPER_C   = 8'h43;
    localparam logic [7:0] CHAR_UPPER_D   = 8'h44;
    localparam logic [7:0] CHAR_UPPER_H   = 8'h48;
    localparam logic [7:0] CHAR_UPPER_J   = 8'h4A;
    localparam logic [7:0] CHAR_UPPER_K   = 8'h4B;
    localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
    localparam logic [7:0] CHAR_LOWER_S   = 8'h73;
    localparam logic [7:0] CHAR_LOWER_U   = 8'h75;

    localparam logic [PARAM_BITS-1:0] CLEAR_ARG = PARAM_BITS'(2);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_req;

    typedef struct packed {
        logic [CMD_BITS-1:0] command;
        logic [ARG_BITS-1:0] arg_first;
        logic [ARG_BITS-1:0] arg_second;
        logic [7:0]          char_out;
        logic                run_last;
    } t_res;

    typedef struct packed {
        logic [1:0]                             mode;
        logic [PARAM_BITS-1:0]                  acc;
        logic [MAX_PARAMS-1:0][PARAM_BITS-1:0]  params;
        logic [PCNT_W-1:0]                      count;
    } t_state;

    // Results caused by one request, packed from index 0 upward.
    typedef struct packed {
        logic [RCNT_W-1:0]           count;
        t_res [MAX_RESULTS-1:0]      items;
    } t_step;

endpackage

// ===== src/acsi_decode.sv =====
// Byte decoder: next parser state and the results caused by one byte.
module acsi_decode (
    input  acsi_pkg::t_req   i_req,
    input  acsi_pkg::t_state i_state,
    output acsi_pkg::t_state o_state,
    output acsi_pkg::t_step  o_step
);

    localparam int SUM_W = acsi_pkg::PARAM_BITS + 4;

    logic [7:0]                              w_byte;
    logic                                    w_eob;
    logic [7:0]                              w_diff;
    logic [SUM_W-1:0]                        w_sum;
    logic [acsi_pkg::PARAM_BITS-1:0]         w_acc_sat;
    logic [acsi_pkg::PARAM_BITS-1:0]         w_p0;
    logic [acsi_pkg::PARAM_BITS-1:0]         w_mv;
    logic                                    w_do_store;
    logic                                    w_do_dispatch;
    logic                                    w_do_ground;
    logic [acsi_pkg::MAX_RESULTS-1:0]        w_slot_v;
    acsi_pkg::t_res [acsi_pkg::MAX_RESULTS-1:0] w_slot;
    acsi_pkg::t_state                        w_next;
    acsi_pkg::t_step                         w_step;

    function automatic acsi_pkg::t_res make_res(
        input logic [acsi_pkg::CMD_BITS-1:0]   cmd,
        input logic [acsi_pkg::PARAM_BITS-1:0] a,
        input logic [acsi_pkg::PARAM_BITS-1:0] b,
        input logic [7:0]                      ch
    );
        acsi_pkg::t_res r;
        r.command    = cmd;
        r.arg_first  = acsi_pkg::ARG_BITS'(a);
        r.arg_second = acsi_pkg::ARG_BITS'(b);
        r.char_out   = ch;
        r.run_last   = 1'b0;
        return r;
    endfunction

    assign w_byte = i_req.data_byte;
    assign w_eob  = i_req.end_of_buffer;

    // Decimal accumulate with saturation at the all-ones value.
    assign w_diff = w_byte - acsi_pkg::CHAR_ZERO;
    assign w_sum  = SUM_W'(i_state.acc) * SUM_W'(acsi_pkg::DEC_BASE) + SUM_W'(w_diff[3:0]);
    assign w_acc_sat = (|w_sum[SUM_W-1:acsi_pkg::PARAM_BITS]) ? '1
                                                              : w_sum[acsi_pkg::PARAM_BITS-1:0];

    always_comb begin
        w_next        = i_state;
        w_slot        = '0;
        w_slot_v      = '0;
        w_do_store    = 1'b0;
        w_do_dispatch = 1'b0;
        w_do_ground   = 1'b0;

        case (i_state.mode)
            acsi_pkg::MODE_ESC: begin
                if (w_byte == acsi_pkg::CHAR_LBRACKET && !w_eob) begin
                    w_next.mode   = acsi_pkg::MODE_CSI;
                    w_next.acc    = '0;
                    w_next.params = '0;
                    w_next.count  = '0;
                end else begin
                    // Lone escape: print it, then treat this byte as ground text.
                    w_next.mode = acsi_pkg::MODE_GROUND;
                    w_slot_v[0] = 1'b1;
                    w_slot[0]   = make_res(acsi_pkg::CMD_PUTCHAR, '0, '0, acsi_pkg::CHAR_ESC);
                    w_do_ground = 1'b1;
                end
            end
            acsi_pkg::MODE_CSI: begin
                if (w_byte inside {[acsi_pkg::CHAR_ZERO:acsi_pkg::CHAR_NINE]}) begin
                    w_next.acc = w_acc_sat;
                end else if (w_byte == acsi_pkg::CHAR_SEMICOLON) begin
                    w_do_store = 1'b1;
                end else begin
                    w_do_store    = (i_state.acc != '0);
                    w_do_dispatch = 1'b1;
                end
            end
            default: begin
                w_next.mode = acsi_pkg::MODE_GROUND;
                w_do_ground = 1'b1;
            end
        endcase

        if (w_do_store) begin
            for (int k = 0; k < acsi_pkg::MAX_PARAMS; k++) begin
                if (i_state.count == acsi_pkg::PCNT_W'(k)) begin
                    w_next.params[k] = i_state.acc;
                end
            end
            if (i_state.count < acsi_pkg::PCNT_W'(acsi_pkg::MAX_PARAMS)) begin
                w_next.count = i_state.count + 1'b1;
            end
            w_next.acc = '0;
        end

        w_p0 = w_next.params[0];
        w_mv = (w_p0 == '0) ? acsi_pkg::PARAM_BITS'(1) : w_p0;

        if (w_do_dispatch) begin
            w_next.mode = acsi_pkg::MODE_GROUND;
            w_next.acc  = '0;
            w_slot_v[1] = 1'b1;
            case (w_byte)
                acsi_pkg::CHAR_UPPER_H,
                acsi_pkg::CHAR_LOWER_F: w_slot[1] = make_res(acsi_pkg::CMD_SETPOS, w_p0,
                                                             w_next.params[1], '0);
                acsi_pkg::CHAR_UPPER_A: w_slot[1] = make_res(acsi_pkg::CMD_UP, w_mv, '0, '0);
                acsi_pkg::CHAR_UPPER_B: w_slot[1] = make_res(acsi_pkg::CMD_DOWN, w_mv, '0, '0);
                acsi_pkg::CHAR_UPPER_C: w_slot[1] = make_res(acsi_pkg::CMD_FWD, w_mv, '0, '0);
                acsi_pkg::CHAR_UPPER_D: w_slot[1] = make_res(acsi_pkg::CMD_BACK, w_mv, '0, '0);
                acsi_pkg::CHAR_LOWER_S: w_slot[1] = make_res(acsi_pkg::CMD_SAVE, '0, '0, '0);
                acsi_pkg::CHAR_LOWER_U: w_slot[1] = make_res(acsi_pkg::CMD_RESTORE, '0, '0, '0);
                acsi_pkg::CHAR_UPPER_K: w_slot[1] = make_res(acsi_pkg::CMD_ERASELINE, '0, '0, '0);
                acsi_pkg::CHAR_UPPER_J: begin
                    w_slot[1]   = make_res(acsi_pkg::CMD_CLEAR, '0, '0, '0);
                    w_slot_v[1] = (w_p0 == acsi_pkg::CLEAR_ARG);
                end
                default: w_slot_v[1] = 1'b0;
            endcase
        end

        if (w_do_ground) begin
            w_slot_v[1] = 1'b1;
            case (w_byte)
                acsi_pkg::CHAR_ESC: begin
                    // An escape that does not end the buffer opens a new sequence.
                    w_slot[1]   = make_res(acsi_pkg::CMD_PUTCHAR, '0, '0, w_byte);
                    w_slot_v[1] = w_eob;
                    if (!w_eob) begin
                        w_next.mode = acsi_pkg::MODE_ESC;
                    end
                end
                acsi_pkg::CHAR_BS:    w_slot[1] = make_res(acsi_pkg::CMD_BS, '0, '0, '0);
                acsi_pkg::CHAR_HT:    w_slot[1] = make_res(acsi_pkg::CMD_HTAB, '0, '0, '0);
                acsi_pkg::CHAR_VT:    w_slot[1] = make_res(acsi_pkg::CMD_VTAB, '0, '0, '0);
                acsi_pkg::CHAR_BEL:   w_slot[1] = make_res(acsi_pkg::CMD_BEEP, '0, '0, '0);
                acsi_pkg::CHAR_CR:    w_slot[1] = make_res(acsi_pkg::CMD_CR, '0, '0, '0);
                acsi_pkg::CHAR_LF:    w_slot[1] = make_res(acsi_pkg::CMD_LF, '0, '0, '0);
                acsi_pkg::CHAR_SPACE: w_slot[1] = make_res(acsi_pkg::CMD_SPACE, '0, '0, '0);
                acsi_pkg::CHAR_DEL:   w_slot[1] = make_res(acsi_pkg::CMD_DEL, '0, '0, '0);
                default:              w_slot[1] = make_res(acsi_pkg::CMD_PUTCHAR, '0, '0, w_byte);
            endcase
        end

        // A buffer end drops any open sequence and always asks for a refresh.
        if (w_eob) begin
            w_next.mode = acsi_pkg::MODE_GROUND;
            w_next.acc  = '0;
            w_slot_v[2] = 1'b1;
            w_slot[2]   = make_res(acsi_pkg::CMD_REFRESH, '0, '0, '0);
        end

        w_step = '0;
        for (int k = 0; k < acsi_pkg::MAX_RESULTS; k++) begin
            if (w_slot_v[k]) begin
                w_step.items[w_step.count[1:0]] = w_slot[k];
                w_step.count                    = w_step.count + 1'b1;
            end
        end
        if (w_step.count != '0) begin
            w_step.items[2'(w_step.count - 1'b1)].run_last = 1'b1;
        end
    end

    assign o_state = w_next;
    assign o_step  = w_step;

endmodule

// ===== src/ansi_csi_control_decoder.sv =====
// Top level of the terminal control decoder: input register, parser state, result buffer.
//
//  Channel | Handshake                | Payload
//  --------+--------------------------+-------------------------------
//  input   | i_in_valid / o_in_ready  | i_in_data  (byte, buffer end)
//  output  | o_out_valid / i_out_ready| o_out_data (command, args, char)
//
// A byte waits in the input register, is decoded there in one pass, and its
// results are loaded into a three-entry result buffer.
// A byte causing at most one result moves on every cycle while the output is
// ready; a byte causing k results holds the input register while the buffer drains.
// Synchronous active-low reset returns the parser to ground and empties both
// registers; a stall on the output holds the buffer and, through it, the input.
module ansi_csi_control_decoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  acsi_pkg::t_req   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output acsi_pkg::t_res   o_out_data
);

    `include "ansi_csi_control_decoder_assert.svh"

    logic                                        r_in_valid;
    logic                                        n_in_valid;
    acsi_pkg::t_req                              r_in;
    acsi_pkg::t_state                            r_state;
    acsi_pkg::t_state                            n_state;
    acsi_pkg::t_res [acsi_pkg::MAX_RESULTS-1:0]  r_res;
    acsi_pkg::t_res [acsi_pkg::MAX_RESULTS-1:0]  n_res;
    logic [acsi_pkg::RCNT_W-1:0]                 r_cnt;
    logic [acsi_pkg::RCNT_W-1:0]                 n_cnt;
    acsi_pkg::t_state                            w_dec_state;
    acsi_pkg::t_step                             w_step;
    logic                                        w_take;
    logic                                        w_buf_free;
    logic                                        w_adv;

    acsi_decode u_decode (
        .i_req   (r_in),
        .i_state (r_state),
        .o_state (w_dec_state),
        .o_step  (w_step)
    );

    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_res[0];
    assign w_take      = o_out_valid && i_out_ready;
    // The buffer can take a new batch when empty or once its last entry leaves this cycle.
    assign w_buf_free  = (r_cnt == '0) || (r_cnt == acsi_pkg::RCNT_W'(1) && i_out_ready);
    assign w_adv       = r_in_valid && w_buf_free;
    assign o_in_ready  = !r_in_valid || w_adv;

    always_comb begin
        n_in_valid = r_in_valid;
        n_state    = r_state;
        n_res      = r_res;
        n_cnt      = r_cnt;
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
        end
        if (w_adv) begin
            n_state = w_dec_state;
            n_res   = w_step.items;
            n_cnt   = w_step.count;
        end else if (w_take) begin
            for (int k = 0; k < acsi_pkg::MAX_RESULTS - 1; k++) begin
                n_res[k] = r_res[k+1];
            end
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_cnt      <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            r_state    <= n_state;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
        r_res <= n_res;
    end

    `ACSI_ASSERT_IMP(a_last_marked, r_cnt == acsi_pkg::RCNT_W'(1), r_res[0].run_last,
                     "final buffered result lacks the last-result mark")
    `ACSI_ASSERT_IMP(a_early_unmarked, r_cnt > acsi_pkg::RCNT_W'(1), !r_res[0].run_last,
                     "last-result mark shown before the final result")
    `ACSI_ASSERT_NXT(a_eob_ground, w_adv && r_in.end_of_buffer,
                     r_state.mode == acsi_pkg::MODE_GROUND && r_state.acc == '0,
                     "parser not back in ground after a buffer end")
    `ACSI_ASSERT_IMP(a_char_zero, o_out_valid && o_out_data.command != acsi_pkg::CMD_PUTCHAR,
                     o_out_data.char_out == '0,
                     "character field set on a non-print command")
    `ACSI_ASSERT_IMP(a_count_range, 1'b1,
                     r_state.count <= acsi_pkg::PCNT_W'(acsi_pkg::MAX_PARAMS),
                     "parameter count beyond the parameter store")

endmodule
